/* sv/chunked_transfer_stream_decoder_unit_defines.svh */
// Assertion macros used by the chunked transfer decoder parser.
`ifndef CHUNKED_TRANSFER_STREAM_DECODER_UNIT_DEFINES_SVH
`define CHUNKED_TRANSFER_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTSD_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("chunked decoder check failed");

// Next-cycle implication, checked outside reset.
`define CTSD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("chunked decoder check failed");

`endif

/* sv/ctsd_pkg.sv */
// Shared types, character codes and helper functions of the chunked decoder.
package ctsd_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam int unsigned HEX_DIGIT_BITS = 4;

    // One decoded result, as it leaves the parser.
    typedef struct packed {
        logic       parse_error;
        logic       body_done;
        logic       out_valid;
        logic [7:0] out_byte;
    } ctsd_result_t;

    // Returns {is_hex, value}; value is zero when the byte is not a hex digit.
    function automatic logic [HEX_DIGIT_BITS:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        logic [HEX_DIGIT_BITS:0] r;
        begin
            v = 8'h00;
            r = '0;
            if (c inside {[8'h30:8'h39]})
            begin
                v = c - 8'h30;
                r = {1'b1, v[HEX_DIGIT_BITS-1:0]};
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                v = c - 8'h57;
                r = {1'b1, v[HEX_DIGIT_BITS-1:0]};
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                v = c - 8'h37;
                r = {1'b1, v[HEX_DIGIT_BITS-1:0]};
            end
            return r;
        end
    endfunction

endpackage

/* sv/ctsd_parser.sv */
// Chunk framing state machine: size line parsing, payload count and error tracking.
`include "chunked_transfer_stream_decoder_unit_defines.svh"

module ctsd_parser
    import ctsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    output ctsd_result_t result
);

    typedef enum logic [2:0] {
        PH_SKIP     = 3'd0,
        PH_SIZE     = 3'd1,
        PH_DATA     = 3'd2,
        PH_DONE     = 3'd3,
        PH_ERR      = 3'd4,
        PH_ERR_DONE = 3'd5
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   remaining_reg, remaining_next;
    logic                     saw_digit_reg, saw_digit_next;
    logic                     digits_ended_reg, digits_ended_next;

    logic [HEX_DIGIT_BITS:0]   hex;
    logic                      is_hex;
    logic [HEX_DIGIT_BITS-1:0] hex_val;
    logic                      is_eol;
    logic [COUNT_WIDTH-1:0]    rem_dec;
    logic [COUNT_WIDTH-1:0]    rem_shift;

    assign hex     = hex_decode(data_byte);
    assign is_hex  = hex[HEX_DIGIT_BITS];
    assign hex_val = hex[HEX_DIGIT_BITS-1:0];
    assign is_eol  = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
    assign rem_dec = remaining_reg - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // Another digit would push bits off the top, so the count saturates.
    always_comb
    begin
        if (remaining_reg[COUNT_WIDTH-1 -: HEX_DIGIT_BITS] != '0)
            rem_shift = '1;
        else
            rem_shift = {remaining_reg[COUNT_WIDTH-HEX_DIGIT_BITS-1:0], hex_val};
    end

    always_comb
    begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        saw_digit_next    = saw_digit_reg;
        digits_ended_next = digits_ended_reg;
        result.out_byte   = 8'h00;
        result.out_valid  = 1'b0;
        case (phase_reg)
            PH_SKIP:
            begin
                if (!is_eol)
                begin
                    phase_next = PH_SIZE;
                    if (is_hex)
                    begin
                        remaining_next    = {{(COUNT_WIDTH-HEX_DIGIT_BITS){1'b0}}, hex_val};
                        saw_digit_next    = 1'b1;
                        digits_ended_next = 1'b0;
                    end
                    else
                    begin
                        remaining_next    = '0;
                        saw_digit_next    = 1'b0;
                        digits_ended_next = 1'b1;
                    end
                end
            end
            PH_SIZE:
            begin
                if (data_byte == CHAR_LF)
                begin
                    if (!saw_digit_reg)
                        phase_next = PH_ERR;
                    else if (remaining_reg == '0)
                        phase_next = PH_DONE;
                    else
                        phase_next = PH_DATA;
                    saw_digit_next    = 1'b0;
                    digits_ended_next = 1'b0;
                end
                else if (is_hex && !digits_ended_reg)
                begin
                    remaining_next = rem_shift;
                    saw_digit_next = 1'b1;
                end
                else
                begin
                    digits_ended_next = 1'b1;
                end
            end
            PH_DATA:
            begin
                result.out_byte  = data_byte;
                result.out_valid = 1'b1;
                remaining_next   = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_SKIP;
            end
            PH_DONE:
            begin
                if (!is_eol)
                    phase_next = PH_ERR_DONE;
            end
            PH_ERR_DONE:
            begin
                phase_next = PH_ERR_DONE;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
        result.body_done   = (phase_next == PH_DONE) || (phase_next == PH_ERR_DONE);
        result.parse_error = (phase_next == PH_ERR) || (phase_next == PH_ERR_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SKIP;
            remaining_reg    <= '0;
            saw_digit_reg    <= 1'b0;
            digits_ended_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            saw_digit_reg    <= saw_digit_next;
            digits_ended_reg <= digits_ended_next;
        end
    end

    // Errors are sticky until reset.
    `CTSD_ASSERT_NEXT(a_err_sticky, clk, rst_n, phase_reg == PH_ERR, phase_reg == PH_ERR)
    `CTSD_ASSERT_NEXT(a_err_done_sticky, clk, rst_n,
        phase_reg == PH_ERR_DONE, phase_reg == PH_ERR_DONE)
    // The last payload byte of a chunk returns to line-end skipping.
    `CTSD_ASSERT_NEXT(a_chunk_end, clk, rst_n,
        step && phase_reg == PH_DATA && remaining_reg == COUNT_WIDTH'(1),
        phase_reg == PH_SKIP)
    // A size line ending without any digit is a format error.
    `CTSD_ASSERT_NEXT(a_no_digit, clk, rst_n,
        step && phase_reg == PH_SIZE && data_byte == CHAR_LF && !saw_digit_reg,
        phase_reg == PH_ERR)
    // The payload counter is never zero while a chunk is being passed on.
    `CTSD_ASSERT_SAME(a_data_count, clk, rst_n, phase_reg == PH_DATA, remaining_reg != '0)

endmodule

/* sv/ctsd_skid.sv */
// Two-entry output buffer that decouples the result stream from the parser.
module ctsd_skid
    import ctsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctsd_result_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output ctsd_result_t out_data
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    ctsd_result_t main_data_reg;
    ctsd_result_t skid_data_reg;

    // Ready depends only on a register, so no path runs from out_ready to in_ready.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                main_data_reg <= skid_data_reg;
            else
                main_data_reg <= in_data;
        end
        else if (in_valid && in_ready)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

/* sv/chunked_transfer_stream_decoder_unit.sv */
// Throughput: one byte per cycle while the master side keeps taking results; the parser state
// and counter update together at each step. The parser steps only while the request register
// holds a byte and the two-entry output buffer has room.
// Reset (rst_n low, asynchronous) returns the parser to line-end skipping with a zero count,
// and empties the request register and the output buffer.
module chunked_transfer_stream_decoder_unit
    import ctsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser    // [0] out_valid, [1] body_done, [2] parse_error
);

    // Request register: holds one raw byte in front of the parser.
    logic         req_valid_reg;
    logic [7:0]   req_byte_reg;

    logic         buf_ready;
    logic         step;
    ctsd_result_t parsed;
    ctsd_result_t out_res;

    // The parser takes the held byte whenever the output buffer has room.
    // Because the buffer's ready comes straight from a register, a fresh request
    // can be taken in the same cycle as the held one moves on.
    assign step     = req_valid_reg && buf_ready;
    assign s_tready = !req_valid_reg || buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_byte_reg <= s_tdata;
        end
    end

    // Framing state machine: one step per byte.
    ctsd_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (req_byte_reg),
        .result    (parsed)
    );

    // Output buffer: a stalled master side never stops the parser while a
    // spare entry remains.
    ctsd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid_reg),
        .in_ready  (buf_ready),
        .in_data   (parsed),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.parse_error, out_res.body_done, out_res.out_valid};

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the chunked transfer decoder, with its own byte-level predictor.
module tb_top
    import ctsd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COUNT_WIDTH    = 32;
    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 6;
    localparam int unsigned RANDOM_ITEMS   = 1080;
    localparam int unsigned HOLD_AT_ITEM   = 300;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASE_ITEMS    = 120;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned QUIET_LIMIT    = 3000;
    localparam int unsigned REPORT_CAP     = 100;
    localparam int          DIRECTED_ROWS  = 22;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam ctsd_result_t           RESULT_NONE = '0;

    // Where the parser stands within the body.
    typedef enum logic [2:0]
    {
        ST_SKIP,
        ST_SIZE,
        ST_DATA,
        ST_DONE,
        ST_ERR,
        ST_ERR_DONE
    } decode_state_e;

    // Which side of the stream idles during the current stretch of requests.
    typedef enum logic [1:0]
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    // How the body is brought to a close; an error is sticky, so only one ending fits a run.
    typedef enum logic [1:0]
    {
        TAIL_CLEAN,
        TAIL_JUNK_AFTER_END,
        TAIL_NO_DIGIT,
        TAIL_OVERFLOW
    } tail_kind_e;

    // One row of the directed table; the result is typed in only where it is obvious.
    typedef struct
    {
        logic [7:0]   data;
        bit           typed;
        ctsd_result_t want;
    } stim_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic [2:0] m_tuser;   // [0] out_valid, [1] body_done, [2] parse_error

    // Predictor state, kept in step with every request handed to the block.
    decode_state_e          dec_state      = ST_SKIP;
    logic [COUNT_WIDTH-1:0] size_count     = '0;
    logic                   line_has_digit = 1'b0;
    logic                   digits_closed  = 1'b0;

    ctsd_result_t  expected_q[$];
    stim_row_t     directed_rows [DIRECTED_ROWS];
    int unsigned   sent_count     = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles   = 0;
    idle_mode_e    idle_mode      = IDLE_NONE;
    bit            hold_off_req   = 1'b0;

    chunked_transfer_stream_decoder_unit
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Classifies a byte as a hexadecimal digit: {is_hex, value}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
            return {1'b1, v[3:0]};
        end
        if (c >= "a" && c <= "f")
        begin
            v = c - "a" + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // Advances the predicted parser by one byte and returns the result the block must give.
    function automatic ctsd_result_t decode_step(input logic [7:0] c);
        ctsd_result_t r;
        logic [4:0]   hv;
        r  = RESULT_NONE;
        hv = hex_nibble(c);
        case (dec_state)
            ST_SKIP:
            begin
                // Line ends before a size line are simply swallowed.
                if (c != CHAR_CR && c != CHAR_LF)
                begin
                    dec_state = ST_SIZE;
                    if (hv[4])
                    begin
                        size_count     = COUNT_WIDTH'(hv[3:0]);
                        line_has_digit = 1'b1;
                        digits_closed  = 1'b0;
                    end
                    else
                    begin
                        // A line opening with a non-digit is all extension.
                        size_count     = '0;
                        line_has_digit = 1'b0;
                        digits_closed  = 1'b1;
                    end
                end
            end
            ST_SIZE:
            begin
                if (c == CHAR_LF)
                begin
                    if (!line_has_digit)
                        dec_state = ST_ERR;
                    else if (size_count == '0)
                        dec_state = ST_DONE;
                    else
                        dec_state = ST_DATA;
                    line_has_digit = 1'b0;
                    digits_closed  = 1'b0;
                end
                else if (hv[4] && !digits_closed)
                begin
                    // The count sticks at all ones once another digit would overflow it.
                    if (size_count > (COUNT_MAX >> 4))
                        size_count = COUNT_MAX;
                    else
                        size_count = {size_count[COUNT_WIDTH-5:0], hv[3:0]};
                    line_has_digit = 1'b1;
                end
                else
                begin
                    digits_closed = 1'b1;
                end
            end
            ST_DATA:
            begin
                r.out_byte  = c;
                r.out_valid = 1'b1;
                size_count  = size_count - COUNT_WIDTH'(1);
                if (size_count == '0)
                    dec_state = ST_SKIP;
            end
            ST_DONE:
            begin
                if (c != CHAR_CR && c != CHAR_LF)
                    dec_state = ST_ERR_DONE;
            end
            ST_ERR_DONE:
            begin
            end
            default:
            begin
                dec_state = ST_ERR;
            end
        endcase
        r.body_done   = (dec_state == ST_DONE || dec_state == ST_ERR_DONE);
        r.parse_error = (dec_state == ST_ERR || dec_state == ST_ERR_DONE);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
            return "0" + v;
        return (upper ? "A" : "a") + v - 8'd10;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    // Any byte except LF, so that it cannot close a size line.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
        begin
            b = rand_byte();
        end
        while (b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] line_end_byte();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    // Offers one request, holding it until the block takes it. The expectation is queued
    // up front, which is safe because the result cannot appear before the request is taken.
    task automatic send_byte(input logic [7:0] b, input bit typed, input ctsd_result_t want);
        ctsd_result_t predicted;
        int unsigned  gap_pct;
        predicted = decode_step(b);
        expected_q.push_back(typed ? want : predicted);
        gap_pct = (idle_mode == IDLE_SEND) ? 46 : (idle_mode == IDLE_BOTH) ? 28 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        // Cycle through the idling patterns so that gaps land on every parser phase.
        idle_mode = idle_mode_e'((sent_count / PHASE_ITEMS) % 4);
        if (sent_count == HOLD_AT_ITEM)
            hold_off_req = 1'b1;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, RESULT_NONE);
    endtask

    // A chunk extension: a non-digit opener followed by noise, stray CRs and ignored digits.
    task automatic send_extension();
        case ($urandom_range(0, 2))
            0: send_plain(";");
            1: send_plain(" ");
            default: send_plain("\t");
        endcase
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 3))
                0: send_plain(rand_hex_char());
                1: send_plain(CHAR_CR);
                default: send_plain(noise_byte());
            endcase
        end
    endtask

    // One well-formed chunk with random framing and random payload.
    task automatic send_chunk();
        logic [31:0] len;
        int          nibbles;
        int          i;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
                send_plain(line_end_byte());
        end
        // Mostly short chunks, a few long ones to exercise wider counts.
        case ($urandom_range(0, 19))
            0: len = $urandom_range(65, 400);
            1, 2, 3, 4, 5: len = $urandom_range(17, 64);
            default: len = $urandom_range(1, 16);
        endcase
        nibbles = (len > 32'hFF) ? 3 : (len > 32'hF) ? 2 : 1;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
                send_plain("0");
        end
        for (i = nibbles - 1; i >= 0; i--)
            send_plain(hex_char(len[i*4 +: 4], 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 2) == 0)
            send_extension();
        if ($urandom_range(0, 3) != 0)
            send_plain(CHAR_CR);
        send_plain(CHAR_LF);
        repeat (len)
            send_plain(rand_byte());
    endtask

    // Closes the body in one of four ways, picked by the seed.
    task automatic send_tail();
        tail_kind_e kind;
        logic [7:0] b;
        logic [4:0] hv;
        kind = tail_kind_e'($urandom_range(0, 3));
        case (kind)
            TAIL_CLEAN:
            begin
                // Zero-size line, then only line ends, which are absorbed.
                send_plain("0");
                if ($urandom_range(0, 1))
                    send_extension();
                send_plain(CHAR_CR);
                send_plain(CHAR_LF);
                repeat ($urandom_range(2, 8))
                    send_plain(line_end_byte());
            end
            TAIL_JUNK_AFTER_END:
            begin
                // Anything but CR or LF after the end is an error; the rest is dropped.
                send_plain("0");
                send_plain(CHAR_LF);
                repeat ($urandom_range(0, 3))
                    send_plain(line_end_byte());
                do
                begin
                    b = rand_byte();
                end
                while (b == CHAR_CR || b == CHAR_LF);
                send_plain(b);
                repeat (12)
                    send_plain(rand_byte());
            end
            TAIL_NO_DIGIT:
            begin
                // A size line led by a non-digit: later digits are extension, so the LF
                // finds no size and the parser locks into its error state.
                do
                begin
                    b  = rand_byte();
                    hv = hex_nibble(b);
                end
                while (b == CHAR_CR || b == CHAR_LF || hv[4]);
                send_plain(b);
                repeat ($urandom_range(0, 4))
                    send_plain(rand_hex_char());
                send_plain(CHAR_LF);
                repeat (12)
                    send_plain(rand_byte());
            end
            default:
            begin
                // Nine or more significant digits overflow the count, which then saturates;
                // everything that follows is payload.
                send_plain(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat ($urandom_range(8, 11))
                    send_plain(rand_hex_char());
                send_plain(CHAR_CR);
                send_plain(CHAR_LF);
                repeat (20)
                    send_plain(rand_byte());
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
        end
    endtask

    // Result side: check every completed request against the oldest expectation, then
    // decide on back-pressure for the next cycle.
    always @(posedge clk)
    begin
        ctsd_result_t got;
        ctsd_result_t want;
        int unsigned  stall_pct;
        int unsigned  hold_left;
        bit           hold_started;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("out_byte", want.out_byte, got.out_byte);
                compare_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
                compare_field("body_done", 8'(want.body_done), 8'(got.body_done));
                compare_field("parse_error", 8'(want.parse_error), 8'(got.parse_error));
            end
        end
        // One long hold-off lets the block fill up and push back on the request side.
        if (hold_off_req && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        stall_pct = (idle_mode == IDLE_RECV) ? 46 : (idle_mode == IDLE_BOTH) ? 28 : 0;
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: a run that stops moving requests on both sides has hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int r;
        // Directed part: field extremes, upper and lower case digits, a leading zero, a
        // lone CR inside an extension, a digit after the extension, and CR/LF as payload.
        directed_rows = '{
            '{"2",     1'b1, RESULT_NONE},
            '{CHAR_CR, 1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{8'h00,   1'b1, ctsd_result_t'{1'b0, 1'b0, 1'b1, 8'h00}},
            '{8'hFF,   1'b1, ctsd_result_t'{1'b0, 1'b0, 1'b1, 8'hFF}},
            '{CHAR_CR, 1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{"3",     1'b0, RESULT_NONE},
            '{";",     1'b0, RESULT_NONE},
            '{"a",     1'b0, RESULT_NONE},
            '{CHAR_CR, 1'b0, RESULT_NONE},
            '{"F",     1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{CHAR_CR, 1'b0, RESULT_NONE},
            '{"0",     1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{"0",     1'b0, RESULT_NONE},
            '{"1",     1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE},
            '{8'h80,   1'b0, RESULT_NONE},
            '{CHAR_LF, 1'b0, RESULT_NONE}
        };
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (r = 0; r < DIRECTED_ROWS; r++)
            send_byte(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].want);
        // Random part: well-formed chunks until the budget is spent, then one ending.
        while (sent_count < RANDOM_ITEMS)
            send_chunk();
        send_tail();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
